>>> hw/rtl/acsp_pkg.sv
package acsp_pkg;

    // Fixed field and state widths.
    localparam int CHAR_W        = 8;
    localparam int ACC_W         = 48;
    localparam int CODE_W        = 52;
    localparam int CFG_W         = 64;
    localparam int DIGIT_FIELD_W = 4;
    localparam int SYM_W         = 5;
    localparam int ERR_W         = 2;

    // Padded bus widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    // Default limits for the top-level parameters.
    localparam int LETTER_COUNT_DEF = 3;
    localparam int MAX_DIGITS_DEF   = 10;

    // Radix multipliers for the accumulator.
    localparam logic [ACC_W-1:0] RADIX_LETTER = ACC_W'(26);
    localparam logic [ACC_W-1:0] RADIX_DIGIT  = ACC_W'(10);

    // ASCII range bounds.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

    // Reset value of the reserved code register.
    localparam logic [CFG_W-1:0] INVALID_CODE_RST = '1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_COUNT    = 2'd1,
        ERR_RESERVED = 2'd2
    } acsp_err_t;

    // Decoded character.
    typedef struct packed {
        logic             is_letter;
        logic             is_digit;
        logic [SYM_W-1:0] sym;
    } acsp_class_t;

    // One finished string.
    typedef struct packed {
        logic [CODE_W-1:0] packed_code;
        acsp_err_t         err;
    } acsp_result_t;

endpackage

>>> hw/rtl/acsp_char_class.sv
module acsp_char_class
(
    input  logic [acsp_pkg::CHAR_W-1:0] char_code,
    output acsp_pkg::acsp_class_t       cls
);

    logic upper;
    logic lower;
    logic digit;

    // Range checks on the raw byte; bytes at or above 128 fall in no range.
    assign upper = (char_code >= acsp_pkg::CHAR_UPPER_A) && (char_code <= acsp_pkg::CHAR_UPPER_Z);
    assign lower = (char_code >= acsp_pkg::CHAR_LOWER_A) && (char_code <= acsp_pkg::CHAR_LOWER_Z);
    assign digit = (char_code >= acsp_pkg::CHAR_ZERO) && (char_code <= acsp_pkg::CHAR_NINE);

    // Symbol value relative to the start of its range.
    always_comb
    begin
        cls.is_letter = upper || lower;
        cls.is_digit  = digit;
        if (upper)
        begin
            cls.sym = acsp_pkg::SYM_W'(char_code - acsp_pkg::CHAR_UPPER_A);
        end
        else if (lower)
        begin
            cls.sym = acsp_pkg::SYM_W'(char_code - acsp_pkg::CHAR_LOWER_A);
        end
        else if (digit)
        begin
            cls.sym = acsp_pkg::SYM_W'(char_code - acsp_pkg::CHAR_ZERO);
        end
        else
        begin
            cls.sym = '0;
        end
    end

endmodule

>>> hw/rtl/acsp_fold.sv
module acsp_fold
#(
    parameter int LETTER_COUNT = acsp_pkg::LETTER_COUNT_DEF,
    parameter int MAX_DIGITS   = acsp_pkg::MAX_DIGITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       is_last,
    input  acsp_pkg::acsp_class_t      cls,
    input  logic [acsp_pkg::CFG_W-1:0] invalid_code,
    output acsp_pkg::acsp_result_t     result
);

    localparam int LW    = $clog2(LETTER_COUNT + 2);
    localparam int DW    = $clog2(MAX_DIGITS + 2);
    localparam int ACW   = acsp_pkg::ACC_W;
    localparam int DFW   = acsp_pkg::DIGIT_FIELD_W;
    localparam int CDW   = acsp_pkg::CODE_W;
    localparam int CFW   = acsp_pkg::CFG_W;
    localparam logic [LW-1:0] LETTER_LIM = LW'(LETTER_COUNT);
    localparam logic [DW-1:0] DIGIT_LIM  = DW'(MAX_DIGITS);

    logic [ACW-1:0] acc_reg;
    logic [ACW-1:0] acc_next;
    logic [ACW-1:0] acc_x10;
    logic [ACW-1:0] acc_x26;
    logic [LW-1:0]  lc_reg;
    logic [LW-1:0]  lc_next;
    logic [DW-1:0]  dc_reg;
    logic [DW-1:0]  dc_next;
    logic [CDW-1:0] code;
    logic           count_bad;

    // Radix products built from shifts: 10 = 8 + 2 and 26 = 10 + 16.
    assign acc_x10 = (acc_reg << 3) + (acc_reg << 1);
    assign acc_x26 = acc_x10 + (acc_reg << 4);

    // Saturating counts and the mixed-radix fold for this character.
    always_comb
    begin
        lc_next  = lc_reg;
        dc_next  = dc_reg;
        acc_next = acc_reg;
        if (cls.is_letter && (lc_reg <= LETTER_LIM))
        begin
            lc_next = lc_reg + LW'(1);
        end
        if (cls.is_digit && (dc_reg <= DIGIT_LIM))
        begin
            dc_next = dc_reg + DW'(1);
        end
        if ((cls.is_letter || cls.is_digit) && (lc_next <= LETTER_LIM) &&
            (dc_next <= DIGIT_LIM))
        begin
            acc_next = (cls.is_letter ? acc_x26 : acc_x10) + ACW'(cls.sym);
        end
    end

    // Final checks on the updated state.
    assign count_bad = (lc_next != LETTER_LIM) || (dc_next == '0) || (dc_next > DIGIT_LIM);
    assign code      = {acc_next, DFW'(dc_next) - DFW'(1)};

    always_comb
    begin
        if (count_bad)
        begin
            result.packed_code = '0;
            result.err         = acsp_pkg::ERR_COUNT;
        end
        else if (CFW'(code) == invalid_code)
        begin
            result.packed_code = '0;
            result.err         = acsp_pkg::ERR_RESERVED;
        end
        else
        begin
            result.packed_code = code;
            result.err         = acsp_pkg::ERR_NONE;
        end
    end

    // State registers; the last character of a string clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            lc_reg  <= '0;
            dc_reg  <= '0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                acc_reg <= '0;
                lc_reg  <= '0;
                dc_reg  <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                lc_reg  <= lc_next;
                dc_reg  <= dc_next;
            end
        end
    end

endmodule

>>> hw/rtl/accession_string_packer_core.sv
// Path: the last character is held in the input register, then folded into the result
// register, which raises m_axis_tvalid; the result transfer can follow.
// Throughput: one character per cycle unless a last character waits; the fold of the state registers sets it.
// A last character waits in the input register only while an earlier result is not taken.
// Reset (rst_n, asynchronous, active low) clears the fold state, both valid flags, and
// sets the reserved code register to all ones.
module accession_string_packer_core
#(
    parameter int LETTER_COUNT = acsp_pkg::LETTER_COUNT_DEF,
    parameter int MAX_DIGITS   = acsp_pkg::MAX_DIGITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [acsp_pkg::CFG_W-1:0]     cfg_wr_data,   // invalid_code
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [acsp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_code
    input  logic                           s_axis_tlast,  // is_last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [acsp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [51:0] packed_code, rest zero
    output logic [acsp_pkg::ERR_W-1:0]     m_axis_tuser   // [1:0] error_kind
);

    localparam int CDW = acsp_pkg::CODE_W;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [acsp_pkg::CHAR_W-1:0]   in_char_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [CDW-1:0]                out_code_reg;
    acsp_pkg::acsp_err_t           out_err_reg;
    logic [acsp_pkg::CFG_W-1:0]    invalid_code_reg;
    logic                          s_xfer;
    logic                          step;
    acsp_pkg::acsp_class_t         cls;
    acsp_pkg::acsp_result_t        result;

    // Reserved code register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_code_reg <= acsp_pkg::INVALID_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            invalid_code_reg <= cfg_wr_data;
        end
    end

    // A character moves on unless it ends a string and the result slot is occupied and not being taken.
    assign step          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_char_reg <= s_axis_tdata[acsp_pkg::CHAR_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    acsp_char_class u_class
    (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    acsp_fold
    #(
        .LETTER_COUNT (LETTER_COUNT),
        .MAX_DIGITS   (MAX_DIGITS)
    )
    u_fold
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .is_last      (in_last_reg),
        .cls          (cls),
        .invalid_code (invalid_code_reg),
        .result       (result)
    );

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_code_reg <= result.packed_code;
            out_err_reg  <= result.err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = acsp_pkg::M_TDATA_W'(out_code_reg);
    assign m_axis_tuser  = out_err_reg;

`ifndef SYNTHESIS
    // An error result always carries a zero code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg != acsp_pkg::ERR_NONE)) |-> (out_code_reg == '0))
        else $error("error result with nonzero code");

    // A good result holds a digit count within the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg == acsp_pkg::ERR_NONE))
        |-> (out_code_reg[acsp_pkg::DIGIT_FIELD_W-1:0] < acsp_pkg::DIGIT_FIELD_W'(MAX_DIGITS)))
        else $error("digit field out of range");

    // A result only appears after the last character of a string advanced.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && in_last_reg))
        else $error("result without a last character");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LETTER_LIMIT  = acsp_pkg::LETTER_COUNT_DEF;
    localparam int DIGIT_LIMIT   = acsp_pkg::MAX_DIGITS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 3000;

    typedef logic [acsp_pkg::CHAR_W-1:0] char_t;

    // One character on its way to the block.
    typedef struct {
        char_t ch;
        logic  last;
    } char_item_t;

    // Fold state of the string being packed.
    typedef struct packed {
        logic [acsp_pkg::ACC_W-1:0] acc;
        logic [2:0]                 letters;
        logic [3:0]                 digits;
    } fold_state_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [acsp_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [acsp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;   // [7:0] char_code
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [acsp_pkg::M_TDATA_W-1:0] m_axis_tdata;        // [51:0] packed_code, rest zero
    logic [acsp_pkg::ERR_W-1:0]     m_axis_tuser;        // [1:0] error_kind

    char_item_t             pending_chars[$];
    acsp_pkg::acsp_result_t expected_codes[$];
    char_t                  reserved_text[$];

    fold_state_t                string_state = '0;
    logic [acsp_pkg::CFG_W-1:0] reserved_mirror = acsp_pkg::INVALID_CODE_RST;
    logic                       char_taken = 1'b0;
    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    int                         hold_requests = 0;
    int                         hold_served = 0;
    int                         hold_left = 0;
    int                         stuck_cycles = 0;
    int                         mismatch_count = 0;

    accession_string_packer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic is_letter(char_t ch);
        return (ch >= acsp_pkg::CHAR_UPPER_A && ch <= acsp_pkg::CHAR_UPPER_Z) ||
               (ch >= acsp_pkg::CHAR_LOWER_A && ch <= acsp_pkg::CHAR_LOWER_Z);
    endfunction

    function automatic logic is_digit(char_t ch);
        return ch >= acsp_pkg::CHAR_ZERO && ch <= acsp_pkg::CHAR_NINE;
    endfunction

    // Folds one character into the string state. Counts saturate one past their
    // limits, and the accumulator freezes once either limit is exceeded.
    function automatic fold_state_t fold_char(fold_state_t st, char_t ch);
        fold_state_t                nx;
        logic [acsp_pkg::ACC_W-1:0] sym;
        nx = st;
        if (ch >= acsp_pkg::CHAR_UPPER_A && ch <= acsp_pkg::CHAR_UPPER_Z)
            sym = acsp_pkg::ACC_W'(ch - acsp_pkg::CHAR_UPPER_A);
        else if (ch >= acsp_pkg::CHAR_LOWER_A && ch <= acsp_pkg::CHAR_LOWER_Z)
            sym = acsp_pkg::ACC_W'(ch - acsp_pkg::CHAR_LOWER_A);
        else
            sym = acsp_pkg::ACC_W'(ch - acsp_pkg::CHAR_ZERO);
        if (is_letter(ch) || is_digit(ch))
        begin
            if (is_letter(ch) && nx.letters <= LETTER_LIMIT)
                nx.letters = nx.letters + 3'd1;
            if (is_digit(ch) && nx.digits <= DIGIT_LIMIT)
                nx.digits = nx.digits + 4'd1;
            if (nx.letters <= LETTER_LIMIT && nx.digits <= DIGIT_LIMIT)
                nx.acc = st.acc *
                         (is_letter(ch) ? acsp_pkg::RADIX_LETTER : acsp_pkg::RADIX_DIGIT) +
                         sym;
        end
        return nx;
    endfunction

    // Result for a finished string under the given reserved code.
    function automatic acsp_pkg::acsp_result_t close_string(fold_state_t st,
                                                            logic [acsp_pkg::CFG_W-1:0] reserved);
        acsp_pkg::acsp_result_t res;
        res.packed_code = '0;
        if (st.letters != LETTER_LIMIT || st.digits == 0 || st.digits > DIGIT_LIMIT)
            res.err = acsp_pkg::ERR_COUNT;
        else
        begin
            res.packed_code = {st.acc, st.digits - 4'd1};
            if (acsp_pkg::CFG_W'(res.packed_code) == reserved)
            begin
                res.packed_code = '0;
                res.err = acsp_pkg::ERR_RESERVED;
            end
            else
                res.err = acsp_pkg::ERR_NONE;
        end
        return res;
    endfunction

    // Packed code of a well-formed string, used to aim the reserved register at it.
    function automatic logic [acsp_pkg::CODE_W-1:0] code_of(char_t text[$]);
        fold_state_t            st;
        acsp_pkg::acsp_result_t res;
        st = '0;
        foreach (text[i])
            st = fold_char(st, text[i]);
        res = close_string(st, '1);
        return res.packed_code;
    endfunction

    function automatic char_t noise_char();
        char_t ch;
        do
            ch = char_t'($urandom_range(255));
        while (is_letter(ch) || is_digit(ch));
        return ch;
    endfunction

    // Queues a string; every character counts as one item.
    task automatic push_text(input char_t text[$], inout int counted);
        char_item_t item;
        for (int i = 0; i < text.size(); i++)
        begin
            item.ch = text[i];
            item.last = (i == text.size() - 1);
            pending_chars.insert(pending_chars.size(), item);
            counted++;
        end
    endtask

    // Mostly well-formed accessions with random content, the rest broken counts
    // or plain noise. The string that hits the reserved code comes back now and then.
    task automatic add_random_string(inout int counted);
        char_t text[$];
        char_t ch;
        int    kind;
        int    letters;
        int    digits;
        logic  shuffle;
        kind = $urandom_range(99);
        if (reserved_text.size() > 0 && kind < 4)
        begin
            push_text(reserved_text, counted);
            return;
        end
        if (kind < 72)
        begin
            letters = LETTER_LIMIT;
            digits = $urandom_range(DIGIT_LIMIT, 1);
        end
        else if (kind < 92)
        begin
            letters = $urandom_range(6, 0);
            digits = $urandom_range(14, 0);
        end
        else
        begin
            letters = 0;
            digits = 0;
        end
        shuffle = ($urandom_range(99) < 20);
        for (int i = 0; i < letters + digits; i++)
        begin
            if (i < letters)
                ch = char_t'($urandom_range(25)) +
                     ($urandom_range(1) ? acsp_pkg::CHAR_UPPER_A : acsp_pkg::CHAR_LOWER_A);
            else
                ch = acsp_pkg::CHAR_ZERO + char_t'($urandom_range(9));
            if (shuffle)
                text.insert($urandom_range(text.size()), ch);
            else
                text.insert(text.size(), ch);
            if ($urandom_range(99) < 8)
                text.insert(text.size(), noise_char());
        end
        if (text.size() == 0 || $urandom_range(99) < 10)
            text.insert(text.size(), noise_char());
        push_text(text, counted);
    endtask

    task automatic run_random(int target);
        int counted;
        counted = 0;
        while (counted < target)
            add_random_string(counted);
    endtask

    // Waits until every character is sent and every result is back, then lets
    // the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_chars.size() != 0 || s_axis_tvalid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reserved(logic [acsp_pkg::CFG_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        reserved_mirror = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Character driver: presents the next queued character once the previous
    // one has made its transfer.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || char_taken))
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_chars[0].ch;
                s_axis_tlast <= pending_chars[0].last;
                void'(pending_chars.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts on each character transfer, checks each result transfer,
    // and stops the run when nothing moves for too long.
    always @(posedge clk)
    begin
        acsp_pkg::acsp_result_t want;
        char_taken <= s_axis_tvalid && s_axis_tready;
        if (!rst_n)
            string_state = '0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                string_state = fold_char(string_state, s_axis_tdata);
                if (s_axis_tlast)
                begin
                    expected_codes.insert(expected_codes.size(),
                                          close_string(string_state, reserved_mirror));
                    string_state = '0;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("result transfer with no string pending: code %h, kind %0d",
                           m_axis_tdata[acsp_pkg::CODE_W-1:0], m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (m_axis_tdata[acsp_pkg::CODE_W-1:0] !== want.packed_code)
                    begin
                        $error("packed_code: expected %h, got %h",
                               want.packed_code, m_axis_tdata[acsp_pkg::CODE_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.err)
                    begin
                        $error("error_kind: expected %0d, got %0d", want.err, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                cfg_wr_en)
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Test sequence: directed strings, then random phases under several reserved
    // codes and handshake patterns.
    initial
    begin
        char_t text[$];
        int    counted;
        counted = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset value of the reserved code, no idling. Range boundaries around the
        // letters and digits, a trailing ignored last byte, ten digits, a lone
        // high byte marked last.
        text = '{8'h40, "a", 8'h60, "Z", 8'h5B, "m", 8'h7B, "/", "0", ":"};
        push_text(text, counted);
        text = '{"X", "y", "Z", "9", "8", "7", "6", "5", "4", "3", "2", "1", "0"};
        push_text(text, counted);
        text = '{8'hFF};
        push_text(text, counted);
        run_random(150);
        wait_idle();

        // Reserved code zero: the all-zero accession hits it. Sender idles.
        write_reserved('0);
        send_idle_pct = 55;
        text = '{"A", "A", "A", "0"};
        reserved_text = text;
        push_text(text, counted);
        text = '{"a", "a", "a", "0", "0"};
        push_text(text, counted);
        text = '{"A", "B", "C", "D", "1"};
        push_text(text, counted);
        run_random(200);
        wait_idle();

        // Reserved code at the largest accession. Receiver stalls.
        text = '{"Z", "z", "Z", "9", "9", "9", "9", "9", "9", "9", "9", "9", "9"};
        reserved_text = text;
        write_reserved(acsp_pkg::CFG_W'(code_of(text)));
        send_idle_pct = 0;
        stall_pct = 55;
        push_text(text, counted);
        text = '{"Z", "z", "Z", "9", "9", "9", "9", "9", "9", "9", "9", "9", "9", "9"};
        push_text(text, counted);
        run_random(200);
        wait_idle();

        // Reserved code at a random accession. Both sides idle a little, and the
        // receiver holds off long enough for the block to back up its input.
        text = '{};
        for (int i = 0; i < LETTER_LIMIT; i++)
            text.insert(text.size(), acsp_pkg::CHAR_UPPER_A + char_t'($urandom_range(25)));
        for (int i = $urandom_range(DIGIT_LIMIT, 1); i > 0; i--)
            text.insert(text.size(), acsp_pkg::CHAR_ZERO + char_t'($urandom_range(9)));
        reserved_text = text;
        write_reserved(acsp_pkg::CFG_W'(code_of(text)));
        send_idle_pct = 10;
        stall_pct = 10;
        push_text(text, counted);
        run_random(100);
        while (pending_chars.size() != 0)
            @(negedge clk);
        hold_requests++;
        run_random(100);
        wait_idle();

        // All ones written back explicitly, no idling.
        reserved_text.delete();
        write_reserved('1);
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(130);
        wait_idle();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
